### sv/mts_pkg.sv
`timescale 1ns / 1ps
package mts_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int OUT_W       = 32;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  // shift request for one chain of cells
  typedef struct packed {
    logic                   push;
    logic                   pop;
    logic [VALUE_WIDTH-1:0] din;
  } mts_shift_t;

endpackage

### sv/min_tracking_stack_core.sv
`timescale 1ns / 1ps
// Stack of signed values that also reports the smallest value it holds.
// Input channel (in_*): in_tuser carries the command (push, pop, status
// read), in_tdata the value to push. Each accepted transfer yields exactly
// one result transfer on out_*: popped value and current minimum in
// out_tdata, flags and status code in out_tuser.
// The result is valid in the cycle after the input transfer. Throughput is
// one item per cycle while out_tready is high: each push or pop shifts a
// row of cells (one for the value stack, one for the minimum stack) by one
// place, so only the top cells are ever read and no memory port limits it.
// A result sits in the output register until taken; a new item is taken
// in the same cycle as the waiting result leaves. While out_tready is low
// and a result waits, in_tready is low and the stack holds.
// Reset (rst_n low, synchronous) empties both stacks by clearing their
// counts and drops any waiting result; stored values are not cleared.
// A push to a full stack is dropped with overflow status, a pop on an
// empty stack returns underflow status; neither changes the stack.
module min_tracking_stack_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] popped_value, [63:32] current_min
  output logic [4:0]  out_tuser   // [0] popped_valid, [1] min_valid,
                                  // [2] is_empty, [4:3] status
);
  import mts_pkg::*;

  logic [CNT_W-1:0] vcnt_r, vcnt_nxt;
  logic [CNT_W-1:0] mcnt_r, mcnt_nxt;
  logic             out_valid_r;
  logic [OUT_W-1:0] popped_r, min_r;
  logic             pvalid_r, mvalid_r, empty_r;
  logic [1:0]       status_r;

  logic [VALUE_WIDTH-1:0] vtop, vsecond, mtop, msecond, val, minv;
  logic                   accept, full, v_empty, m_empty;
  logic                   do_push, do_pop, min_push, min_pop;
  logic [1:0]             status_nxt;
  mts_shift_t             v_shift, m_shift;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign val       = in_tdata[VALUE_WIDTH-1:0];
  assign full      = (vcnt_r == CNT_W'(STACK_DEPTH));
  assign v_empty   = (vcnt_r == '0);
  assign m_empty   = (mcnt_r == '0);

  always_comb begin
    do_push    = 1'b0;
    do_pop     = 1'b0;
    status_nxt = ST_OK;
    unique case (in_tuser)
      CMD_PUSH: begin
        if (full) begin
          status_nxt = ST_OVER;
        end else begin
          do_push = accept;
        end
      end
      CMD_POP: begin
        if (v_empty) begin
          status_nxt = ST_UNDER;
        end else begin
          do_pop = accept;
        end
      end
      CMD_READ: begin
        status_nxt = ST_OK;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // equal values go on the minimum stack again
  assign min_push = do_push && (mcnt_r != CNT_W'(STACK_DEPTH)) &&
                    (m_empty || ($signed(mtop) >= $signed(val)));
  assign min_pop  = do_pop && !m_empty && (mtop == vtop);

  assign v_shift = '{push: do_push, pop: do_pop, din: val};
  assign m_shift = '{push: min_push, pop: min_pop, din: val};

  mts_chain u_values (
    .clk      (clk),
    .shift    (v_shift),
    .top_o    (vtop),
    .second_o (vsecond)
  );

  mts_chain u_minima (
    .clk      (clk),
    .shift    (m_shift),
    .top_o    (mtop),
    .second_o (msecond)
  );

  always_comb begin
    vcnt_nxt = vcnt_r;
    if (do_push) begin
      vcnt_nxt = vcnt_r + CNT_W'(1);
    end else if (do_pop) begin
      vcnt_nxt = vcnt_r - CNT_W'(1);
    end
    mcnt_nxt = mcnt_r;
    if (min_push) begin
      mcnt_nxt = mcnt_r + CNT_W'(1);
    end else if (min_pop) begin
      mcnt_nxt = mcnt_r - CNT_W'(1);
    end
    // minimum after this step, taken from the new top of the minimum chain
    if (min_push) begin
      minv = val;
    end else if (min_pop) begin
      minv = msecond;
    end else begin
      minv = mtop;
    end
    if (vcnt_nxt == '0 || mcnt_nxt == '0) begin
      minv = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r      <= '0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vcnt_r <= vcnt_nxt;
      mcnt_r <= mcnt_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= do_pop ? OUT_W'(vtop) : '0;
      pvalid_r <= do_pop;
      min_r    <= OUT_W'(minv);
      mvalid_r <= (vcnt_nxt != '0);
      empty_r  <= (vcnt_nxt == '0);
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {min_r, popped_r};
  assign out_tuser  = {status_r, empty_r, mvalid_r, pvalid_r};

  // second value cell is part of every chain but only the minimum one uses it
  logic unused_vsecond;
  assign unused_vsecond = ^vsecond;

endmodule

### sv/mts_cell.sv
`timescale 1ns / 1ps
module mts_cell (
  input  logic                           clk,
  input  mts_pkg::mts_shift_t            shift,
  input  logic [mts_pkg::VALUE_WIDTH-1:0] from_up,
  input  logic [mts_pkg::VALUE_WIDTH-1:0] from_down,
  output logic [mts_pkg::VALUE_WIDTH-1:0] data_o
);
  import mts_pkg::*;

  logic [VALUE_WIDTH-1:0] data_r;
  logic [VALUE_WIDTH-1:0] data_nxt;

  // push moves everything one place deeper, pop one place toward the top
  always_comb begin
    data_nxt = data_r;
    if (shift.push) begin
      data_nxt = from_up;
    end else if (shift.pop) begin
      data_nxt = from_down;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

### sv/mts_chain.sv
`timescale 1ns / 1ps
module mts_chain (
  input  logic                            clk,
  input  mts_pkg::mts_shift_t             shift,
  output logic [mts_pkg::VALUE_WIDTH-1:0] top_o,
  output logic [mts_pkg::VALUE_WIDTH-1:0] second_o
);
  import mts_pkg::*;

  logic [VALUE_WIDTH-1:0] cell_q [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] up_d;
    logic [VALUE_WIDTH-1:0] down_d;

    if (i == 0) begin : g_head
      assign up_d = shift.din;
    end else begin : g_body
      assign up_d = cell_q[i-1];
    end

    // bottom cell holds its own value on pop
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign down_d = cell_q[i];
    end else begin : g_link
      assign down_d = cell_q[i+1];
    end

    mts_cell u_cell (
      .clk       (clk),
      .shift     (shift),
      .from_up   (up_d),
      .from_down (down_d),
      .data_o    (cell_q[i])
    );
  end

  assign top_o    = cell_q[0];
  assign second_o = cell_q[1];

endmodule

### verif/min_tracking_stack_core_test.sv
`timescale 1ns / 1ps
module min_tracking_stack_core_test;
  import mts_pkg::*;

  // spare command code; the block treats it like a status read
  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         HOLD_CYCLES = 80;

  typedef struct packed {
    logic [31:0] popped_value;
    logic        popped_valid;
    logic [31:0] current_min;
    logic        min_valid;
    logic        is_empty;
    logic [1:0]  status;
  } stack_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = CMD_READ;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [4:0]  out_tuser;

  // shadow of both stacks
  logic signed [VALUE_WIDTH-1:0] shadow_values [STACK_DEPTH];
  logic signed [VALUE_WIDTH-1:0] shadow_mins [STACK_DEPTH];
  int shadow_depth     = 0;
  int shadow_min_depth = 0;

  stack_result_t awaited_results[$];
  int error_count  = 0;
  int cycle_count  = 0;
  bit idle_enable  = 1'b1;
  bit hold_request = 1'b0;
  int hold_left    = 0;

  min_tracking_stack_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("min_tracking_stack_core_test: errors");
      $finish;
    end
  end

  // Apply one command to the shadow stacks and return the result it yields.
  function automatic stack_result_t apply_stack_command(logic [1:0] cmd, logic [31:0] value);
    stack_result_t res;
    logic signed [VALUE_WIDTH-1:0] v;
    v = value;
    res = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (shadow_depth >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          shadow_values[shadow_depth] = v;
          shadow_depth++;
          // equal values go on again so duplicate minima unwind one by one
          if (shadow_min_depth == 0 || shadow_mins[shadow_min_depth - 1] >= v) begin
            shadow_mins[shadow_min_depth] = v;
            shadow_min_depth++;
          end
        end
      end
      CMD_POP: begin
        if (shadow_depth == 0) begin
          res.status = ST_UNDER;
        end else begin
          shadow_depth--;
          res.popped_value = shadow_values[shadow_depth];
          res.popped_valid = 1'b1;
          if (shadow_min_depth > 0 &&
              shadow_mins[shadow_min_depth - 1] == shadow_values[shadow_depth])
            shadow_min_depth--;
        end
      end
      default: ;
    endcase
    if (shadow_depth > 0) begin
      res.min_valid = 1'b1;
      if (shadow_min_depth > 0)
        res.current_min = shadow_mins[shadow_min_depth - 1];
    end
    res.is_empty = (shadow_depth == 0);
    return res;
  endfunction

  function automatic logic [31:0] pick_value();
    int near;
    case ($urandom_range(9))
      0, 1, 2: begin
        // narrow range so equal minima show up often
        near = $urandom_range(8);
        return 32'(near - 4);
      end
      3: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic send_item(input logic [1:0] cmd, input logic [31:0] value);
    if (idle_enable && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    awaited_results.insert(awaited_results.size(), apply_stack_command(cmd, value));
  endtask

  // Hold the input until every result has been taken.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !idle_enable || ($urandom_range(99) >= 12);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    stack_result_t got;
    stack_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.popped_value = out_tdata[31:0];
      got.current_min  = out_tdata[63:32];
      got.popped_valid = out_tuser[0];
      got.min_valid    = out_tuser[1];
      got.is_empty     = out_tuser[2];
      got.status       = out_tuser[4:3];
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result, popped_value", got.popped_value, '0);
      end else begin
        want = awaited_results.pop_front();
        if (got.popped_value !== want.popped_value)
          report_mismatch("popped_value", got.popped_value, want.popped_value);
        if (got.popped_valid !== want.popped_valid)
          report_mismatch("popped_valid", 32'(got.popped_valid), 32'(want.popped_valid));
        if (got.current_min !== want.current_min)
          report_mismatch("current_min", got.current_min, want.current_min);
        if (got.min_valid !== want.min_valid)
          report_mismatch("min_valid", 32'(got.min_valid), 32'(want.min_valid));
        if (got.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
      end
    end
  end

  task automatic test_directed();
    send_item(CMD_POP,   32'h1234_5678);   // underflow on empty
    send_item(CMD_READ,  32'hFFFF_FFFF);
    send_item(CMD_SPARE, 32'hA5A5_A5A5);
    send_item(CMD_PUSH,  32'h7FFF_FFFF);
    send_item(CMD_PUSH,  32'h8000_0000);
    send_item(CMD_PUSH,  32'h8000_0000);   // equal minimum stacks again
    send_item(CMD_PUSH,  32'h7FFF_FFFF);
    send_item(CMD_PUSH,  32'hFFFF_FFFF);
    send_item(CMD_READ,  32'h0000_0000);
    send_item(CMD_POP,   32'hFFFF_FFFF);
    send_item(CMD_POP,   32'h0000_0000);
    send_item(CMD_POP,   32'h0000_0000);   // first of the duplicate minima
    send_item(CMD_SPARE, 32'h0000_0000);
    send_item(CMD_POP,   32'h0000_0000);
    send_item(CMD_POP,   32'h0000_0000);   // back to empty
    send_item(CMD_POP,   32'h0000_0000);
    send_item(CMD_PUSH,  32'h0000_0000);
    send_item(CMD_PUSH,  32'h0000_0000);
    send_item(CMD_PUSH,  32'h0000_0001);
    send_item(CMD_POP,   32'h0000_0000);
    send_item(CMD_POP,   32'h0000_0000);
    send_item(CMD_POP,   32'h0000_0000);
  endtask

  task automatic test_fill_and_overflow();
    idle_enable = 1'b0;
    hold_request = 1'b1;
    // keep offering pushes while the receiver holds off
    repeat (STACK_DEPTH) send_item(CMD_PUSH, pick_value());
    send_item(CMD_PUSH, 32'h8000_0000);
    send_item(CMD_READ, pick_value());
    send_item(CMD_PUSH, pick_value());
    idle_enable = 1'b1;
    wait_drain();
    repeat (STACK_DEPTH) begin
      if ($urandom_range(9) == 0)
        send_item(CMD_READ, pick_value());
      send_item(CMD_POP, pick_value());
    end
    send_item(CMD_POP, pick_value());
  endtask

  task automatic test_random(input int count);
    int roll;
    bit push_heavy;
    logic [1:0] cmd;
    for (int i = 0; i < count; i++) begin
      // alternate growing and shrinking runs so both ends are reached
      push_heavy = ((i / 50) % 2) == 0;
      idle_enable = !(i >= 150 && i < 250);
      roll = $urandom_range(99);
      if (roll < (push_heavy ? 62 : 30))
        cmd = CMD_PUSH;
      else if (roll < (push_heavy ? 90 : 88))
        cmd = CMD_POP;
      else if (roll < 96)
        cmd = CMD_READ;
      else
        cmd = CMD_SPARE;
      send_item(cmd, pick_value());
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drain();
    test_fill_and_overflow();
    wait_drain();
    test_random(240);
    wait_drain();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("min_tracking_stack_core_test: clean");
    else
      $display("min_tracking_stack_core_test: errors");
    $finish;
  end

endmodule
